// File: src/dtes_pkg.sv
package dtes_pkg;

  localparam int PendingDepth = 16;
  localparam int TrackBits    = 16;
  localparam int ClientBits   = 8;
  localparam int TimeoutBits  = 16;
  localparam int IdxBits      = $clog2(PendingDepth);

  typedef enum logic [1:0] {
    OpRequest = 2'd0,
    OpRelease = 2'd1,
    OpTick    = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StGranted = 2'd0,
    StTimeout = 2'd1,
    StIdle    = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StateIdle,
    StateRequest,
    StateRelScan,
    StateRelDone,
    StateTickScan,
    StateTickDone
  } state_e;

  typedef struct packed {
    logic capture;
    logic request;
    logic rel_scan;
    logic rel_done;
    logic tick_scan;
    logic tick_done;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

// File: src/dtes_ctrl.sv
module dtes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          operation_i,
  input  dtes_pkg::stat_t     stat_i,
  output dtes_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  dtes_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtes_pkg::StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dtes_pkg::StateIdle: begin
        if (start_i) begin
          case (operation_i)
            dtes_pkg::OpRequest: state_d = dtes_pkg::StateRequest;
            dtes_pkg::OpRelease: state_d = dtes_pkg::StateRelScan;
            dtes_pkg::OpTick:    state_d = dtes_pkg::StateTickScan;
            default:             state_d = dtes_pkg::StateIdle;
          endcase
        end
      end
      dtes_pkg::StateRequest: state_d = dtes_pkg::StateIdle;
      dtes_pkg::StateRelScan: begin
        if (stat_i.scan_last) state_d = dtes_pkg::StateRelDone;
      end
      dtes_pkg::StateRelDone: state_d = dtes_pkg::StateIdle;
      dtes_pkg::StateTickScan: begin
        if (stat_i.scan_last) state_d = dtes_pkg::StateTickDone;
      end
      dtes_pkg::StateTickDone: state_d = dtes_pkg::StateIdle;
      default: state_d = dtes_pkg::StateIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      dtes_pkg::StateIdle: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      dtes_pkg::StateRequest:  cmd_o.request   = 1'b1;
      dtes_pkg::StateRelScan:  cmd_o.rel_scan  = 1'b1;
      dtes_pkg::StateRelDone:  cmd_o.rel_done  = 1'b1;
      dtes_pkg::StateTickScan: cmd_o.tick_scan = 1'b1;
      dtes_pkg::StateTickDone: cmd_o.tick_done = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// File: src/dtes_datapath.sv
module dtes_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dtes_pkg::cmd_t                    cmd_i,
  output dtes_pkg::stat_t                   stat_o,
  input  logic [dtes_pkg::ClientBits-1:0]   requester_id_i,
  input  logic [dtes_pkg::TrackBits-1:0]    track_i,
  input  logic [dtes_pkg::TimeoutBits-1:0]  timeout_ticks_i,
  output logic                              result_valid_o,
  output logic [dtes_pkg::ClientBits-1:0]   client_id_o,
  output logic [1:0]                        status_o,
  output logic [dtes_pkg::TrackBits-1:0]    granted_track_o,
  output logic                              last_o
);

  localparam int Depth = dtes_pkg::PendingDepth;
  localparam int IdxW  = dtes_pkg::IdxBits;
  localparam int TrkW  = dtes_pkg::TrackBits;
  localparam int CliW  = dtes_pkg::ClientBits;
  localparam int TmoW  = dtes_pkg::TimeoutBits;

  logic [CliW-1:0] req_client_q;
  logic [TrkW-1:0] req_track_q;
  logic [TmoW-1:0] req_tmo_q;

  logic [CliW-1:0] slot_client_q [Depth];
  logic [TrkW-1:0] slot_track_q  [Depth];
  logic            slot_sweep_q  [Depth];
  logic [TmoW-1:0] slot_rem_q    [Depth];

  logic [Depth-1:0] valid_q, valid_d;
  logic             disk_busy_q, disk_busy_d;
  logic [TrkW-1:0]  head_track_q, head_track_d;
  logic             active_sweep_q, active_sweep_d;
  logic [IdxW-1:0]  idx_q;

  logic            act_found_q, oth_found_q;
  logic [IdxW-1:0] act_idx_q, oth_idx_q;
  logic [TrkW-1:0] act_track_q, oth_track_q;
  logic [CliW-1:0] act_client_q, oth_client_q;

  logic            hold_valid_q, hold_valid_d;
  logic [CliW-1:0] hold_client_q, hold_client_d;
  logic [TrkW-1:0] hold_track_q, hold_track_d;

  logic                  res_valid_q, res_valid_d;
  logic [CliW-1:0]       res_client_q, res_client_d;
  dtes_pkg::status_e     res_status_q, res_status_d;
  logic [TrkW-1:0]       res_track_q, res_track_d;
  logic                  res_last_q, res_last_d;

  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            cur_valid;
  logic            cur_sweep;
  logic [TrkW-1:0] cur_track;
  logic [CliW-1:0] cur_client;
  logic [TmoW-1:0] cur_rem;

  assign cur_valid  = valid_q[idx_q];
  assign cur_sweep  = slot_sweep_q[idx_q];
  assign cur_track  = slot_track_q[idx_q];
  assign cur_client = slot_client_q[idx_q];
  assign cur_rem    = slot_rem_q[idx_q];

  assign stat_o.scan_last = (idx_q == IdxW'(Depth - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < Depth; i++) begin
      if (!free_found && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    valid_d        = valid_q;
    disk_busy_d    = disk_busy_q;
    head_track_d   = head_track_q;
    active_sweep_d = active_sweep_q;
    hold_valid_d   = hold_valid_q;
    hold_client_d  = hold_client_q;
    hold_track_d   = hold_track_q;
    res_valid_d    = 1'b0;
    res_client_d   = res_client_q;
    res_status_d   = res_status_q;
    res_track_d    = res_track_q;
    res_last_d     = res_last_q;

    if (cmd_i.capture) begin
      hold_valid_d = 1'b0;
    end

    if (cmd_i.request) begin
      if (!disk_busy_q) begin
        disk_busy_d  = 1'b1;
        head_track_d = req_track_q;
        res_valid_d  = 1'b1;
        res_client_d = req_client_q;
        res_status_d = dtes_pkg::StGranted;
        res_track_d  = req_track_q;
        res_last_d   = 1'b1;
      end else if (!free_found) begin
        res_valid_d  = 1'b1;
        res_client_d = req_client_q;
        res_status_d = dtes_pkg::StFull;
        res_track_d  = req_track_q;
        res_last_d   = 1'b1;
      end else begin
        valid_d[free_idx] = 1'b1;
      end
    end

    if (cmd_i.rel_done) begin
      res_valid_d = 1'b1;
      res_last_d  = 1'b1;
      if (act_found_q) begin
        head_track_d         = act_track_q;
        valid_d[act_idx_q]   = 1'b0;
        res_client_d         = act_client_q;
        res_status_d         = dtes_pkg::StGranted;
        res_track_d          = act_track_q;
      end else if (oth_found_q) begin
        active_sweep_d       = ~active_sweep_q;
        head_track_d         = oth_track_q;
        valid_d[oth_idx_q]   = 1'b0;
        res_client_d         = oth_client_q;
        res_status_d         = dtes_pkg::StGranted;
        res_track_d          = oth_track_q;
      end else begin
        disk_busy_d  = 1'b0;
        res_client_d = '0;
        res_status_d = dtes_pkg::StIdle;
        res_track_d  = '0;
      end
    end

    if (cmd_i.tick_scan && cur_valid && cur_rem == TmoW'(1)) begin
      valid_d[idx_q] = 1'b0;
      if (hold_valid_q) begin
        res_valid_d  = 1'b1;
        res_client_d = hold_client_q;
        res_status_d = dtes_pkg::StTimeout;
        res_track_d  = hold_track_q;
        res_last_d   = 1'b0;
      end
      hold_valid_d  = 1'b1;
      hold_client_d = cur_client;
      hold_track_d  = cur_track;
    end

    if (cmd_i.tick_done && hold_valid_q) begin
      res_valid_d  = 1'b1;
      res_client_d = hold_client_q;
      res_status_d = dtes_pkg::StTimeout;
      res_track_d  = hold_track_q;
      res_last_d   = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      disk_busy_q    <= 1'b0;
      head_track_q   <= '0;
      active_sweep_q <= 1'b0;
      hold_valid_q   <= 1'b0;
      res_valid_q    <= 1'b0;
      act_found_q    <= 1'b0;
      oth_found_q    <= 1'b0;
      idx_q          <= '0;
    end else begin
      valid_q        <= valid_d;
      disk_busy_q    <= disk_busy_d;
      head_track_q   <= head_track_d;
      active_sweep_q <= active_sweep_d;
      hold_valid_q   <= hold_valid_d;
      res_valid_q    <= res_valid_d;
      if (cmd_i.capture) begin
        idx_q       <= '0;
        act_found_q <= 1'b0;
        oth_found_q <= 1'b0;
      end else if (cmd_i.rel_scan || cmd_i.tick_scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.rel_scan && cur_valid) begin
        if (cur_sweep == active_sweep_q) begin
          if (!act_found_q || cur_track < act_track_q) act_found_q <= 1'b1;
        end else begin
          if (!oth_found_q || cur_track < oth_track_q) oth_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_client_q <= requester_id_i;
      req_track_q  <= track_i;
      req_tmo_q    <= timeout_ticks_i;
    end
    if (cmd_i.request && disk_busy_q && free_found) begin
      slot_client_q[free_idx] <= req_client_q;
      slot_track_q[free_idx]  <= req_track_q;
      slot_sweep_q[free_idx]  <= (req_track_q >= head_track_q) ? active_sweep_q
                                                                : ~active_sweep_q;
      slot_rem_q[free_idx]    <= req_tmo_q;
    end
    if (cmd_i.tick_scan && cur_valid && cur_rem != '0) begin
      slot_rem_q[idx_q] <= cur_rem - 1'b1;
    end
    if (cmd_i.rel_scan && cur_valid) begin
      if (cur_sweep == active_sweep_q) begin
        if (!act_found_q || cur_track < act_track_q) begin
          act_idx_q    <= idx_q;
          act_track_q  <= cur_track;
          act_client_q <= cur_client;
        end
      end else begin
        if (!oth_found_q || cur_track < oth_track_q) begin
          oth_idx_q    <= idx_q;
          oth_track_q  <= cur_track;
          oth_client_q <= cur_client;
        end
      end
    end
    hold_client_q <= hold_client_d;
    hold_track_q  <= hold_track_d;
    res_client_q  <= res_client_d;
    res_status_q  <= res_status_d;
    res_track_q   <= res_track_d;
    res_last_q    <= res_last_d;
  end

  assign result_valid_o  = res_valid_q;
  assign client_id_o     = res_client_q;
  assign status_o        = res_status_q;
  assign granted_track_o = res_track_q;
  assign last_o          = res_last_q;

endmodule

// File: src/disk_track_elevator_scheduler.sv
// Grants one disk to clients in one-direction elevator order. A command beat is taken when
// start_i is high and busy_o is low. A release or a tick walks all 16 pending slots, one
// slot per cycle; an unknown operation gives nothing. Results appear for exactly one cycle
// with result_valid_o high and cannot be held off, so the receiver must take every beat as
// it comes; last_o marks the final result of a command. A tick may give up to 16 timed-out
// results.
module disk_track_elevator_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        operation_i,
  input  logic [dtes_pkg::ClientBits-1:0]   requester_id_i,
  input  logic [dtes_pkg::TrackBits-1:0]    track_i,
  input  logic [dtes_pkg::TimeoutBits-1:0]  timeout_ticks_i,
  output logic                              result_valid_o,
  output logic [dtes_pkg::ClientBits-1:0]   client_id_o,
  output logic [1:0]                        status_o,
  output logic [dtes_pkg::TrackBits-1:0]    granted_track_o,
  output logic                              last_o
);

  dtes_pkg::cmd_t  cmd;
  dtes_pkg::stat_t stat;

  dtes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  dtes_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .requester_id_i  (requester_id_i),
    .track_i         (track_i),
    .timeout_ticks_i (timeout_ticks_i),
    .result_valid_o  (result_valid_o),
    .client_id_o     (client_id_o),
    .status_o        (status_o),
    .granted_track_o (granted_track_o),
    .last_o          (last_o)
  );

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("Non-final result beat seen while the block is idle.");

  a_single_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != dtes_pkg::StTimeout |-> last_o)
    else $error("Grant, idle or full result beat not marked as final.");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == dtes_pkg::StIdle |-> client_id_o == '0
      && granted_track_o == '0)
    else $error("Idle result beat carries a nonzero client or track.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i != dtes_pkg::OpNone |=> busy_o)
    else $error("Accepted command did not make the block busy.");

endmodule
